// ===== hw/rtl/jpae_pkg.sv =====
// Shared types, constants and arithmetic helpers for the per-joint PID effort block.
// No dependencies; every other file of the block imports this package.
package jpae_pkg;

    localparam int JOINTS             = 32;
    localparam int JOINT_W            = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int JOINT_IDX_W        = 5;
    localparam int SETTINGS_PER_JOINT = 8;
    localparam int LIMIT_W            = 31;
    localparam int ACC_W              = 52;
    localparam int DIV_STEPS          = 32;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS);
    localparam int FIFO_DEPTH         = 2;

    localparam logic [31:0]         DT_MIN             = 32'd4295;
    localparam logic [LIMIT_W-1:0]  EFFORT_LIMIT_RESET = 31'd26214400;
    localparam logic signed [31:0]  Q_MIN              = 32'sh8000_0000;
    localparam logic signed [31:0]  Q_MAX              = 32'sh7fff_ffff;

    typedef enum logic {
        OP_STEP = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        SEL_KP    = 3'd0,
        SEL_KI    = 3'd1,
        SEL_KD    = 3'd2,
        SEL_KV    = 3'd3,
        SEL_IMIN  = 3'd4,
        SEL_IMAX  = 3'd5,
        SEL_LOWER = 3'd6,
        SEL_UPPER = 3'd7
    } t_sel;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_TGT, S_ERR, S_DIFF, S_DIV, S_DIVE,
        S_MKI, S_MDT0, S_MDT1, S_INT, S_ICLP, S_KD, S_KV, S_SUM,
        S_CLP, S_TIE, S_TCLP, S_WB, S_LOAD
    } t_bstate;

    typedef struct packed {
        t_op                 op;
        logic [JOINT_W-1:0]  joint;
        t_sel                sel;
        logic signed [31:0]  value;
        logic signed [31:0]  tp;
        logic signed [31:0]  mp;
        logic signed [31:0]  tv;
        logic signed [31:0]  mv;
        logic signed [31:0]  ff;
        logic [31:0]         dt;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic signed [31:0] prev;
        logic signed [31:0] rate;
        logic signed [31:0] integ;
    } t_jstate;

    function automatic logic [31:0] mag32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [31:0] sat33(logic signed [32:0] v);
        if (v[32] != v[31]) return v[32] ? Q_MIN : Q_MAX;
        return v[31:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sext32(logic signed [31:0] v);
        return ACC_W'(v);
    endfunction

    // Q16.16 product magnitude back to Q16.16 with the sign applied afterwards
    function automatic logic signed [ACC_W-1:0] scale_term(logic [63:0] p, logic neg);
        logic signed [ACC_W-1:0] t;
        t = $signed(ACC_W'(p[63:16]));
        return neg ? -t : t;
    endfunction

    // upper bound first, lower bound wins when the bounds cross
    function automatic logic signed [ACC_W-1:0] clamp_acc(logic signed [ACC_W-1:0] v,
                                                         logic signed [ACC_W-1:0] lo,
                                                         logic signed [ACC_W-1:0] hi);
        logic signed [ACC_W-1:0] t;
        t = (v > hi) ? hi : v;
        return (t < lo) ? lo : t;
    endfunction

endpackage

// ===== hw/rtl/jpae_fifo.sv =====
// Two-entry item queue between the front classifier and the back sequencer.
// Depends on jpae_pkg (t_item, t_q_stat, FIFO_DEPTH).
module jpae_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jpae_pkg::t_item   i_item,
    input  logic              i_pop,
    output jpae_pkg::t_item   o_head,
    output jpae_pkg::t_q_stat o_stat
);
    import jpae_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == CNT_W'(FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== hw/rtl/jpae_front.sv =====
// Front classifier: takes input transfers, decodes step/load, drops unknown joints.
// Depends on jpae_pkg; feeds jpae_fifo.
module jpae_front (
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_command,
    input  logic [4:0]        i_joint_index,
    input  logic [2:0]        i_setting_select,
    input  logic signed [31:0] i_setting_value,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_measured_position,
    input  logic signed [31:0] i_target_velocity,
    input  logic signed [31:0] i_measured_velocity,
    input  logic signed [31:0] i_feedforward_effort,
    input  logic [31:0]       i_time_step,
    input  jpae_pkg::t_q_stat i_stat,
    output logic              o_push,
    output jpae_pkg::t_item   o_item
);
    import jpae_pkg::*;

    logic in_range;

    assign in_range   = (int'(i_joint_index) < JOINTS);
    assign o_in_ready = !i_stat.full;
    // out-of-range joints are consumed and vanish
    assign o_push     = i_in_valid && o_in_ready && in_range;

    always_comb begin
        o_item.op    = t_op'(i_command);
        o_item.joint = JOINT_W'(i_joint_index);
        o_item.sel   = t_sel'(i_setting_select);
        o_item.value = i_setting_value;
        o_item.tp    = i_target_position;
        o_item.mp    = i_measured_position;
        o_item.tv    = i_target_velocity;
        o_item.mv    = i_measured_velocity;
        o_item.ff    = i_feedforward_effort;
        o_item.dt    = i_time_step;
    end

endmodule

// ===== hw/rtl/jpae_back.sv =====
// Back sequencer: per-joint setting/state memories, serial divider, shared 32x32
// multiplier and the clamp/tie-back steps. Depends on jpae_pkg; fed by jpae_fifo.
module jpae_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  jpae_pkg::t_item               i_head,
    input  jpae_pkg::t_q_stat             i_stat,
    output logic                          o_pop,
    input  logic [jpae_pkg::LIMIT_W-1:0]  i_effort_limit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [jpae_pkg::JOINT_W-1:0]  o_result_joint,
    output logic signed [31:0]            o_effort,
    output logic                          o_sat
);
    import jpae_pkg::*;

    t_bstate r_state, n_state;
    t_item   r_it;

    // memories
    logic [31:0] r_set_mem [JOINTS][SETTINGS_PER_JOINT];
    t_jstate     r_st_mem  [JOINTS];
    logic [SETTINGS_PER_JOINT-1:0] r_set_vld [JOINTS];
    logic [JOINTS-1:0]             r_st_vld;

    logic [31:0]                   r_set_q [SETTINGS_PER_JOINT];
    logic [SETTINGS_PER_JOINT-1:0] r_set_vq;
    t_jstate                       r_st_q;
    logic                          r_st_vq;

    // datapath
    logic signed [31:0]      r_tgt, r_e, r_verr, r_rate, r_integ, r_c;
    logic [31:0]             r_rem, r_quo, r_m_hi;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic                    r_neg_d, r_sat;
    logic [63:0]             r_prod, r_p0;
    logic signed [ACC_W-1:0] r_isum, r_acc, r_tie;

    logic                    r_out_vld;
    logic [JOINT_W-1:0]      r_out_joint;
    logic signed [31:0]      r_out_effort;
    logic                    r_out_sat;

    logic signed [31:0] sv_kp, sv_ki, sv_kd, sv_kv, sv_imin, sv_imax, sv_lower, sv_upper;
    logic signed [31:0] st_prev, st_rate, st_integ;
    logic signed [31:0] tgt_hi;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [32:0]        rem2;
    logic               div_bit;
    logic [63:0]        inc64;
    logic signed [ACC_W-1:0] inc_s, lim_s, clip, iclamp;
    logic [31:0]        mul_a, mul_b;
    logic               out_free, rd_en, wb_en, ld_en;

    assign sv_kp    = r_set_vq[SEL_KP]    ? $signed(r_set_q[SEL_KP])    : '0;
    assign sv_ki    = r_set_vq[SEL_KI]    ? $signed(r_set_q[SEL_KI])    : '0;
    assign sv_kd    = r_set_vq[SEL_KD]    ? $signed(r_set_q[SEL_KD])    : '0;
    assign sv_kv    = r_set_vq[SEL_KV]    ? $signed(r_set_q[SEL_KV])    : '0;
    assign sv_imin  = r_set_vq[SEL_IMIN]  ? $signed(r_set_q[SEL_IMIN])  : '0;
    assign sv_imax  = r_set_vq[SEL_IMAX]  ? $signed(r_set_q[SEL_IMAX])  : '0;
    assign sv_lower = r_set_vq[SEL_LOWER] ? $signed(r_set_q[SEL_LOWER]) : Q_MIN;
    assign sv_upper = r_set_vq[SEL_UPPER] ? $signed(r_set_q[SEL_UPPER]) : Q_MAX;

    assign st_prev  = r_st_vq ? r_st_q.prev  : '0;
    assign st_rate  = r_st_vq ? r_st_q.rate  : '0;
    assign st_integ = r_st_vq ? r_st_q.integ : '0;

    assign tgt_hi   = (r_it.tp > sv_upper) ? sv_upper : r_it.tp;
    assign diff     = {r_e[31], r_e} - {st_prev[31], st_prev};
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign rem2     = {r_rem, 1'b0};
    assign div_bit  = (rem2 >= {1'b0, r_it.dt});

    // ki*e*dt: hi word product plus carry-in of the low word's upper half
    assign inc64  = r_prod + {32'd0, r_p0[63:32]};
    assign inc_s  = (sv_ki[31] ^ r_e[31]) ? -$signed(ACC_W'(inc64[63:16]))
                                          :  $signed(ACC_W'(inc64[63:16]));
    assign lim_s  = $signed(ACC_W'(i_effort_limit));
    assign clip   = clamp_acc(r_acc, -lim_s, lim_s);
    assign iclamp = clamp_acc(r_isum, sext32(sv_imin), sext32(sv_imax));

    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MKI:  begin mul_a = mag32(sv_ki);   mul_b = mag32(r_e);    end
            S_MDT0: begin mul_a = r_prod[31:0];   mul_b = r_it.dt;       end
            S_MDT1: begin mul_a = r_m_hi;         mul_b = r_it.dt;       end
            S_INT:  begin mul_a = mag32(sv_kp);   mul_b = mag32(r_e);    end
            S_ICLP: begin mul_a = mag32(sv_kd);   mul_b = mag32(r_rate); end
            S_KD:   begin mul_a = mag32(sv_kv);   mul_b = mag32(r_verr); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        wb_en   = 1'b0;
        ld_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop   = 1'b1;
                    n_state = (i_head.op == OP_LOAD) ? S_LOAD : S_RD;
                end
            end
            S_LOAD: begin
                ld_en   = 1'b1;
                n_state = S_IDLE;
            end
            S_RD: begin
                rd_en   = 1'b1;
                n_state = S_TGT;
            end
            S_TGT:  n_state = S_ERR;
            S_ERR:  n_state = S_DIFF;
            S_DIFF: begin
                if (r_it.dt >= DT_MIN && {diff_mag, 1'b0} < {2'b00, r_it.dt})
                    n_state = S_DIV;
                else
                    n_state = S_MKI;
            end
            S_DIV:  if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) n_state = S_DIVE;
            S_DIVE: n_state = S_MKI;
            S_MKI:  n_state = S_MDT0;
            S_MDT0: n_state = S_MDT1;
            S_MDT1: n_state = S_INT;
            S_INT:  n_state = S_ICLP;
            S_ICLP: n_state = S_KD;
            S_KD:   n_state = S_KV;
            S_KV:   n_state = S_SUM;
            S_SUM:  n_state = S_CLP;
            S_CLP:  n_state = S_TIE;
            S_TIE:  n_state = (r_sat && sv_ki != '0) ? S_TCLP : S_WB;
            S_TCLP: n_state = S_WB;
            S_WB: begin
                if (out_free) begin
                    wb_en   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // setting and state memories
    always_ff @(posedge i_clk) begin
        if (ld_en) r_set_mem[r_it.joint][r_it.sel] <= r_it.value;
        if (wb_en) r_st_mem[r_it.joint] <= '{prev: r_e, rate: r_rate, integ: r_integ};
        if (rd_en) begin
            r_set_q <= r_set_mem[r_it.joint];
            r_st_q  <= r_st_mem[r_it.joint];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < JOINTS; j++) r_set_vld[j] <= '0;
            r_st_vld <= '0;
        end else begin
            if (ld_en) r_set_vld[r_it.joint][r_it.sel] <= 1'b1;
            if (wb_en) r_st_vld[r_it.joint] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_set_vq <= r_set_vld[r_it.joint];
            r_st_vq  <= r_st_vld[r_it.joint];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (o_pop) r_it <= i_head;
        case (r_state)
            S_TGT: r_tgt <= (tgt_hi < sv_lower) ? sv_lower : tgt_hi;
            S_ERR: begin
                r_e    <= sat33({r_tgt[31], r_tgt} - {r_it.mp[31], r_it.mp});
                r_verr <= sat33({r_it.tv[31], r_it.tv} - {r_it.mv[31], r_it.mv});
            end
            S_DIFF: begin
                r_neg_d <= diff[32];
                r_rem   <= diff_mag[31:0];
                r_quo   <= '0;
                r_cnt   <= '0;
                if (r_it.dt < DT_MIN)
                    r_rate <= st_rate;
                else if ({diff_mag, 1'b0} >= {2'b00, r_it.dt})
                    r_rate <= diff[32] ? Q_MIN : Q_MAX;
            end
            S_DIV: begin
                r_rem <= div_bit ? 32'(rem2 - {1'b0, r_it.dt}) : rem2[31:0];
                r_quo <= {r_quo[30:0], div_bit};
                r_cnt <= r_cnt + 1'b1;
            end
            S_DIVE: r_rate <= r_neg_d ? -$signed(r_quo) : $signed(r_quo);
            S_MDT0: r_m_hi <= r_prod[63:32];
            S_MDT1: r_p0   <= r_prod;
            S_INT:  r_isum <= sext32(st_integ) + inc_s;
            S_ICLP: begin
                r_integ <= iclamp[31:0];
                r_acc   <= sext32(r_it.ff) + scale_term(r_prod, sv_kp[31] ^ r_e[31]);
            end
            S_KD:  r_acc <= r_acc + scale_term(r_prod, sv_kd[31] ^ r_rate[31]);
            S_KV:  r_acc <= r_acc + scale_term(r_prod, sv_kv[31] ^ r_verr[31]);
            S_SUM: r_acc <= r_acc + sext32(r_integ);
            S_CLP: begin
                r_c   <= clip[31:0];
                r_sat <= (clip != r_acc);
                r_tie <= clip - r_acc;
            end
            S_TIE:  r_isum  <= sext32(r_integ) + r_tie;
            S_TCLP: r_integ <= iclamp[31:0];
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_out_vld <= 1'b0;
        else if (wb_en)       r_out_vld <= 1'b1;
        else if (i_out_ready) r_out_vld <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            r_out_joint  <= r_it.joint;
            r_out_effort <= r_c;
            r_out_sat    <= r_sat;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_result_joint = r_out_joint;
    assign o_effort       = r_out_effort;
    assign o_sat          = r_out_sat;

    a_div_rem_below_dt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_it.dt))
        else $error("divider remainder not below time step");

    a_integ_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB && sv_imin <= sv_imax) |-> (r_integ >= sv_imin && r_integ <= sv_imax))
        else $error("integral outside its bounds at write-back");

    a_unsat_passes_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TIE && !r_sat) |-> (sext32(r_c) == r_acc))
        else $error("unsaturated effort differs from the sum");

endmodule

// ===== hw/rtl/joint_pid_antiwindup_effort.sv =====
// Top level of the per-joint PID effort controller: APB register, front, queue, back.
// Depends on jpae_pkg, jpae_front, jpae_fifo and jpae_back.
//
//   channel   signals                              transfer when
//   ------    -----------------------------------  -------------------------
//   in        i_in_valid/o_in_ready + item fields  i_in_valid & o_in_ready
//   out       o_out_valid/i_out_ready + result     o_out_valid & i_out_ready
//   cfg       psel/penable/pwrite/paddr/pwdata     psel & penable & pwrite
//
// A load passes through S_LOAD in the back sequencer; a step runs S_RD through S_WB, adds
// S_TCLP for the integral tie-back, and S_DIV and S_DIVE when the error rate goes through
// the 32-step serial divider (one quotient bit a cycle).
// The shared 32x32 multiplier is used six times per step.
// A two-entry queue lets the front take transfers while the back is busy.
// Synchronous active-low reset; all settings and joint state read as their reset values.
// A result waits in the output register; the back stalls only if it is still held.
module joint_pid_antiwindup_effort (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_command,
    input  logic [4:0]         i_joint_index,
    input  logic [2:0]         i_setting_select,
    input  logic signed [31:0] i_setting_value,
    input  logic signed [31:0] i_target_position,
    input  logic signed [31:0] i_measured_position,
    input  logic signed [31:0] i_target_velocity,
    input  logic signed [31:0] i_measured_velocity,
    input  logic signed [31:0] i_feedforward_effort,
    input  logic [31:0]        i_time_step,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [4:0]         o_result_joint,
    output logic signed [31:0] o_effort_out,
    output logic               o_saturated
);
    import jpae_pkg::*;

    localparam logic REG_EFFORT_LIMIT = 1'b0;

    logic [LIMIT_W-1:0] r_effort_limit;
    logic               cfg_wr;
    logic               push, pop;
    t_item              item, head;
    t_q_stat            qstat;
    logic [JOINT_W-1:0] res_joint;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EFFORT_LIMIT);
    assign prdata = (paddr[2] == REG_EFFORT_LIMIT) ? {1'b0, r_effort_limit} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)    r_effort_limit <= EFFORT_LIMIT_RESET;
        else if (cfg_wr) r_effort_limit <= pwdata[LIMIT_W-1:0];
    end

    jpae_front u_front (
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_command            (i_command),
        .i_joint_index        (i_joint_index),
        .i_setting_select     (i_setting_select),
        .i_setting_value      (i_setting_value),
        .i_target_position    (i_target_position),
        .i_measured_position  (i_measured_position),
        .i_target_velocity    (i_target_velocity),
        .i_measured_velocity  (i_measured_velocity),
        .i_feedforward_effort (i_feedforward_effort),
        .i_time_step          (i_time_step),
        .i_stat               (qstat),
        .o_push               (push),
        .o_item               (item)
    );

    jpae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    jpae_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_stat         (qstat),
        .o_pop          (pop),
        .i_effort_limit (r_effort_limit),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_joint (res_joint),
        .o_effort       (o_effort_out),
        .o_sat          (o_saturated)
    );

    assign o_result_joint = JOINT_IDX_W'(res_joint);

endmodule
